/* rtl/drts_pkg.sv */
// Shared types, constants and helper functions of the dual reel therapy sequencer.
// Used by the channel interfaces and the top level; depends on nothing else.
package drts_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_BITS-1:0]   cfg_word_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MOVE_TICKS  = 2'd0,
        REG_PAUSE_TICKS = 2'd1,
        REG_JOG_TICKS   = 2'd2
    } cfg_index_t;

    localparam cfg_word_t MOVE_TICKS_RESET  = 16'd2000;
    localparam cfg_word_t PAUSE_TICKS_RESET = 16'd1000;
    localparam cfg_word_t JOG_TICKS_RESET   = 16'd200;

    typedef enum logic [1:0] {
        PH_FLEX       = 2'd0,
        PH_FLEX_PAUSE = 2'd1,
        PH_EXT        = 2'd2,
        PH_EXT_PAUSE  = 2'd3
    } phase_t;

    // Bridge word: ext_drive in bits 1:0, flex_drive in bits 3:2.
    localparam logic [3:0] DRIVE_STOP     = 4'h0;
    localparam logic [3:0] DRIVE_FLEX     = 4'h5;
    localparam logic [3:0] DRIVE_EXT      = 4'hA;
    localparam logic [3:0] JOG_EXT_FWD    = 4'h1;
    localparam logic [3:0] JOG_EXT_REV    = 4'h2;
    localparam logic [3:0] JOG_FLEX_FWD   = 4'h4;
    localparam logic [3:0] JOG_FLEX_REV   = 4'h8;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_E = 8'h65;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_O = 8'h6F;
    localparam logic [7:0] CH_P = 8'h70;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_W = 8'h77;
    localparam logic [7:0] CH_Z = 8'h7A;

    typedef struct packed {
        logic [1:0] ext_drive;
        logic [1:0] flex_drive;
        logic [1:0] phase;
        logic       calibrated;
        logic       paused;
        logic       on_demand_mode;
        logic       on_demand_moving;
    } result_t;

    function automatic timer_t count_up(input timer_t v);
        timer_t r;
        r = (v == {TIMER_BITS{1'b1}}) ? v : timer_t'(v + 1'b1);
        return r;
    endfunction

    function automatic logic reached(input timer_t elapsed, input cfg_word_t limit);
        logic r;
        r = CMP_BITS'(elapsed) >= CMP_BITS'(limit);
        return r;
    endfunction

    function automatic logic [3:0] phase_drive(input phase_t ph);
        logic [3:0] r;
        unique case (ph)
            PH_FLEX: r = DRIVE_FLEX;
            PH_EXT:  r = DRIVE_EXT;
            default: r = DRIVE_STOP;
        endcase
        return r;
    endfunction

endpackage

/* rtl/drts_if.sv */
// Valid/ready channel interfaces of the sequencer: input items, results and
// configuration writes. Depends on drts_pkg.
interface drts_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] command_byte;
    modport source (output valid, output kind, output command_byte, input ready);
    modport sink   (input valid, input kind, input command_byte, output ready);
endinterface

interface drts_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] ext_drive;
    logic [1:0] flex_drive;
    logic [1:0] phase;
    logic       calibrated;
    logic       paused;
    logic       on_demand_mode;
    logic       on_demand_moving;
    modport source (output valid, output ext_drive, output flex_drive, output phase,
                    output calibrated, output paused, output on_demand_mode,
                    output on_demand_moving, input ready);
    modport sink   (input valid, input ext_drive, input flex_drive, input phase,
                    input calibrated, input paused, input on_demand_mode,
                    input on_demand_moving, output ready);
endinterface

interface drts_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [drts_pkg::CFG_IDX_BITS-1:0]   index;
    logic [drts_pkg::CFG_BITS-1:0]       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/dual_reel_therapy_sequencer.sv */
// Top level of the dual reel therapy sequencer: command decoder, jog, cycle and
// on-demand timers, and the result register. Depends on drts_pkg and drts_if.

// The block takes one request per clock (a millisecond tick or a command byte)
// and returns exactly one result per request, registered in the cycle after it is taken.
// The state update for a request is one short pass of logic from the state
// registers into the state and result registers, so the throughput is one
// request per cycle; the only thing that holds off new requests is a result
// register that is still full and not being drained. Configuration writes are
// always accepted and take effect on the next request; there is no clearing
// pass after reset.
module dual_reel_therapy_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,
    drts_item_if.sink             item,
    drts_result_if.source         result,
    drts_cfg_if.sink              cfg
);

    drts_pkg::cfg_word_t move_ticks_reg;
    drts_pkg::cfg_word_t pause_ticks_reg;
    drts_pkg::cfg_word_t jog_ticks_reg;

    logic                calibrated_reg, calibrated_next;
    logic                paused_reg, paused_next;
    logic                demand_mode_reg, demand_mode_next;
    logic                demand_active_reg, demand_active_next;
    drts_pkg::phase_t    phase_reg, phase_next;
    drts_pkg::timer_t    phase_elapsed_reg, phase_elapsed_next;
    drts_pkg::timer_t    demand_elapsed_reg, demand_elapsed_next;
    drts_pkg::cfg_word_t jog_remaining_reg, jog_remaining_next;
    logic [3:0]          bridge_reg, bridge_next;

    drts_pkg::result_t   result_reg, result_next;
    logic                out_valid_reg;
    logic                accept;
    logic [7:0]          ch;

    assign cfg.ready  = 1'b1;
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_ticks_reg  <= drts_pkg::MOVE_TICKS_RESET;
            pause_ticks_reg <= drts_pkg::PAUSE_TICKS_RESET;
            jog_ticks_reg   <= drts_pkg::JOG_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                drts_pkg::REG_MOVE_TICKS:  move_ticks_reg  <= cfg.data;
                drts_pkg::REG_PAUSE_TICKS: pause_ticks_reg <= cfg.data;
                drts_pkg::REG_JOG_TICKS:   jog_ticks_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        calibrated_next     = calibrated_reg;
        paused_next         = paused_reg;
        demand_mode_next    = demand_mode_reg;
        demand_active_next  = demand_active_reg;
        phase_next          = phase_reg;
        phase_elapsed_next  = phase_elapsed_reg;
        demand_elapsed_next = demand_elapsed_reg;
        jog_remaining_next  = jog_remaining_reg;
        bridge_next         = bridge_reg;
        ch                  = item.command_byte;

        if (!item.kind)
        begin
            if (jog_remaining_next != '0)
            begin
                jog_remaining_next = jog_remaining_next - 1'b1;
                if (jog_remaining_next == '0)
                    bridge_next = drts_pkg::DRIVE_STOP;
            end
            if (demand_mode_reg && demand_active_reg && !paused_reg)
            begin
                demand_elapsed_next = drts_pkg::count_up(demand_elapsed_reg);
                if (drts_pkg::reached(demand_elapsed_next, move_ticks_reg))
                begin
                    demand_active_next = 1'b0;
                    bridge_next        = drts_pkg::DRIVE_STOP;
                end
            end
            if (calibrated_reg && !paused_reg && !demand_mode_reg)
            begin
                phase_elapsed_next = drts_pkg::count_up(phase_elapsed_reg);
                if (drts_pkg::reached(phase_elapsed_next,
                        phase_reg[0] ? pause_ticks_reg : move_ticks_reg))
                begin
                    phase_next         = drts_pkg::phase_t'(phase_reg + 2'd1);
                    phase_elapsed_next = '0;
                    bridge_next        = drts_pkg::phase_drive(phase_next);
                end
            end
        end
        else if (ch != drts_pkg::CH_LF && ch != drts_pkg::CH_CR &&
                 ch != drts_pkg::CH_SPACE)
        begin
            if (ch >= drts_pkg::CH_UP_A && ch <= drts_pkg::CH_UP_Z)
                ch = ch + drts_pkg::CASE_OFFSET;

            // Any real command cuts a running jog pulse short.
            if (jog_remaining_next != '0)
            begin
                jog_remaining_next = '0;
                bridge_next        = drts_pkg::DRIVE_STOP;
            end

            if (!calibrated_reg)
            begin
                if (ch == drts_pkg::CH_W || ch == drts_pkg::CH_S ||
                    ch == drts_pkg::CH_D || ch == drts_pkg::CH_A)
                begin
                    if (jog_ticks_reg == '0)
                    begin
                        bridge_next = drts_pkg::DRIVE_STOP;
                    end
                    else
                    begin
                        jog_remaining_next = jog_ticks_reg;
                        priority if (ch == drts_pkg::CH_W)
                            bridge_next = drts_pkg::JOG_EXT_FWD;
                        else if (ch == drts_pkg::CH_S)
                            bridge_next = drts_pkg::JOG_EXT_REV;
                        else if (ch == drts_pkg::CH_D)
                            bridge_next = drts_pkg::JOG_FLEX_FWD;
                        else
                            bridge_next = drts_pkg::JOG_FLEX_REV;
                    end
                end
                else if (ch == drts_pkg::CH_Z)
                begin
                    calibrated_next    = 1'b1;
                    paused_next        = 1'b0;
                    demand_mode_next   = 1'b0;
                    demand_active_next = 1'b0;
                    phase_next         = drts_pkg::PH_FLEX;
                    phase_elapsed_next = '0;
                    bridge_next        = drts_pkg::DRIVE_FLEX;
                end
            end
            else
            begin
                if (ch == drts_pkg::CH_M)
                begin
                    demand_mode_next   = 1'b1;
                    demand_active_next = 1'b0;
                    bridge_next        = drts_pkg::DRIVE_STOP;
                end
                else if (ch == drts_pkg::CH_L || ch == drts_pkg::CH_E)
                begin
                    if (demand_mode_reg && !paused_reg)
                    begin
                        bridge_next = (ch == drts_pkg::CH_L) ? drts_pkg::DRIVE_FLEX
                                                             : drts_pkg::DRIVE_EXT;
                        demand_active_next  = 1'b1;
                        demand_elapsed_next = '0;
                    end
                end
                else if (ch == drts_pkg::CH_O)
                begin
                    demand_active_next = 1'b0;
                    bridge_next        = drts_pkg::DRIVE_STOP;
                end
                else if (ch == drts_pkg::CH_Z)
                begin
                    demand_mode_next   = 1'b0;
                    demand_active_next = 1'b0;
                    paused_next        = 1'b0;
                    phase_next         = drts_pkg::PH_FLEX;
                    phase_elapsed_next = '0;
                    bridge_next        = drts_pkg::DRIVE_FLEX;
                end
            end

            if (ch == drts_pkg::CH_P)
            begin
                paused_next = !paused_reg;
                if (!paused_reg)
                begin
                    demand_active_next = 1'b0;
                    bridge_next        = drts_pkg::DRIVE_STOP;
                end
                else
                begin
                    // Resuming restarts the current phase from zero.
                    phase_elapsed_next = '0;
                    if (!demand_mode_reg)
                        bridge_next = drts_pkg::phase_drive(phase_reg);
                end
            end

            if (ch == drts_pkg::CH_R)
            begin
                calibrated_next    = 1'b0;
                paused_next        = 1'b0;
                demand_mode_next   = 1'b0;
                demand_active_next = 1'b0;
                bridge_next        = drts_pkg::DRIVE_STOP;
            end
        end

        result_next.ext_drive        = bridge_next[1:0];
        result_next.flex_drive       = bridge_next[3:2];
        result_next.phase            = phase_next;
        result_next.calibrated       = calibrated_next;
        result_next.paused           = paused_next;
        result_next.on_demand_mode   = demand_mode_next;
        result_next.on_demand_moving = demand_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrated_reg     <= 1'b0;
            paused_reg         <= 1'b0;
            demand_mode_reg    <= 1'b0;
            demand_active_reg  <= 1'b0;
            phase_reg          <= drts_pkg::PH_FLEX;
            phase_elapsed_reg  <= '0;
            demand_elapsed_reg <= '0;
            jog_remaining_reg  <= '0;
            bridge_reg         <= drts_pkg::DRIVE_STOP;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                calibrated_reg     <= calibrated_next;
                paused_reg         <= paused_next;
                demand_mode_reg    <= demand_mode_next;
                demand_active_reg  <= demand_active_next;
                phase_reg          <= phase_next;
                phase_elapsed_reg  <= phase_elapsed_next;
                demand_elapsed_reg <= demand_elapsed_next;
                jog_remaining_reg  <= jog_remaining_next;
                bridge_reg         <= bridge_next;
                out_valid_reg      <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.ext_drive        = result_reg.ext_drive;
    assign result.flex_drive       = result_reg.flex_drive;
    assign result.phase            = result_reg.phase;
    assign result.calibrated       = result_reg.calibrated;
    assign result.paused           = result_reg.paused;
    assign result.on_demand_mode   = result_reg.on_demand_mode;
    assign result.on_demand_moving = result_reg.on_demand_moving;

endmodule

/* tb/tb_dual_reel_therapy_sequencer.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the dual reel therapy sequencer: a directed table, then rounds
// of random ticks and command requests, each result compared against its pinned value or a behavioral predictor.
// Depends on drts_pkg, the channel interfaces in drts_if and the dual_reel_therapy_sequencer top.
module tb_dual_reel_therapy_sequencer;

    localparam int ROUNDS      = 6;
    localparam int ROUND_ITEMS = 250;
    localparam int IDLE_PCT    = 33;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    typedef enum logic { STEP_ITEM, STEP_CFG } step_kind_t;

    typedef struct {
        step_kind_t          what;
        logic                kind;
        logic [7:0]          cmd;
        bit                  pinned;
        drts_pkg::result_t   want;
        drts_pkg::cfg_word_t move_v;
        drts_pkg::cfg_word_t pause_v;
        drts_pkg::cfg_word_t jog_v;
    } step_t;

    typedef struct {
        bit                pinned;
        drts_pkg::result_t want;
    } pin_t;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   mismatch_count;

    step_t             steps[$];
    pin_t              pinned_q[$];
    drts_pkg::result_t expected_outputs[$];

    // Predictor copy of the sequencer state and its registers.
    drts_pkg::cfg_word_t move_len      = drts_pkg::MOVE_TICKS_RESET;
    drts_pkg::cfg_word_t pause_len     = drts_pkg::PAUSE_TICKS_RESET;
    drts_pkg::cfg_word_t jog_len       = drts_pkg::JOG_TICKS_RESET;
    logic                is_cal        = 1'b0;
    logic                sys_paused    = 1'b0;
    logic                demand_mode   = 1'b0;
    logic                demand_moving = 1'b0;
    drts_pkg::phase_t    cur_phase     = drts_pkg::PH_FLEX;
    drts_pkg::timer_t    phase_time    = '0;
    drts_pkg::timer_t    demand_time   = '0;
    drts_pkg::cfg_word_t jog_left      = '0;
    logic [3:0]          bridge_word   = drts_pkg::DRIVE_STOP;

    drts_item_if   item_ch ();
    drts_result_if result_ch ();
    drts_cfg_if    cfg_ch ();

    dual_reel_therapy_sequencer u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic drts_pkg::timer_t bump_timer(input drts_pkg::timer_t v);
        if (&v)
            return v;
        return v + 1'b1;
    endfunction

    function automatic drts_pkg::result_t pin_outs(input logic [1:0] e, input logic [1:0] f,
                                                   input drts_pkg::phase_t ph, input logic c,
                                                   input logic p, input logic m,
                                                   input logic mv);
        drts_pkg::result_t r;
        r.ext_drive        = e;
        r.flex_drive       = f;
        r.phase            = ph;
        r.calibrated       = c;
        r.paused           = p;
        r.on_demand_mode   = m;
        r.on_demand_moving = mv;
        return r;
    endfunction

    task automatic enter_phase(input drts_pkg::phase_t ph);
        cur_phase  = ph;
        phase_time = '0;
        case (ph)
            drts_pkg::PH_FLEX: bridge_word = drts_pkg::DRIVE_FLEX;
            drts_pkg::PH_EXT:  bridge_word = drts_pkg::DRIVE_EXT;
            default:           bridge_word = drts_pkg::DRIVE_STOP;
        endcase
    endtask

    task automatic start_jog(input logic [3:0] pattern);
        if (jog_len == '0)
        begin
            bridge_word = drts_pkg::DRIVE_STOP;
            jog_left    = '0;
        end
        else
        begin
            bridge_word = pattern;
            jog_left    = jog_len;
        end
    endtask

    task automatic predict_outputs(input logic k, input logic [7:0] b,
                                   output drts_pkg::result_t r);
        logic [7:0]          c;
        drts_pkg::cfg_word_t limit;
        logic [1:0]          nxt;
        c = b;
        if (k == KIND_TICK)
        begin
            if (jog_left != '0)
            begin
                jog_left = jog_left - 1'b1;
                if (jog_left == '0)
                    bridge_word = drts_pkg::DRIVE_STOP;
            end
            if (demand_mode && demand_moving && !sys_paused)
            begin
                demand_time = bump_timer(demand_time);
                if (demand_time >= move_len)
                begin
                    demand_moving = 1'b0;
                    bridge_word   = drts_pkg::DRIVE_STOP;
                end
            end
            if (is_cal && !sys_paused && !demand_mode)
            begin
                limit      = cur_phase[0] ? pause_len : move_len;
                phase_time = bump_timer(phase_time);
                if (phase_time >= limit)
                begin
                    nxt = cur_phase + 2'd1;
                    enter_phase(drts_pkg::phase_t'(nxt));
                end
            end
        end
        else if (c != drts_pkg::CH_LF && c != drts_pkg::CH_CR && c != drts_pkg::CH_SPACE)
        begin
            if (c >= drts_pkg::CH_UP_A && c <= drts_pkg::CH_UP_Z)
                c = c + drts_pkg::CASE_OFFSET;
            // Any command that is not whitespace cuts a running jog short.
            if (jog_left != '0)
            begin
                jog_left    = '0;
                bridge_word = drts_pkg::DRIVE_STOP;
            end
            if (!is_cal)
            begin
                case (c)
                    drts_pkg::CH_W: start_jog(drts_pkg::JOG_EXT_FWD);
                    drts_pkg::CH_S: start_jog(drts_pkg::JOG_EXT_REV);
                    drts_pkg::CH_D: start_jog(drts_pkg::JOG_FLEX_FWD);
                    drts_pkg::CH_A: start_jog(drts_pkg::JOG_FLEX_REV);
                    drts_pkg::CH_Z:
                    begin
                        is_cal        = 1'b1;
                        sys_paused    = 1'b0;
                        demand_mode   = 1'b0;
                        demand_moving = 1'b0;
                        enter_phase(drts_pkg::PH_FLEX);
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (c)
                    drts_pkg::CH_M:
                    begin
                        demand_mode   = 1'b1;
                        demand_moving = 1'b0;
                        bridge_word   = drts_pkg::DRIVE_STOP;
                    end
                    drts_pkg::CH_L, drts_pkg::CH_E:
                    begin
                        if (demand_mode && !sys_paused)
                        begin
                            bridge_word   = (c == drts_pkg::CH_L) ? drts_pkg::DRIVE_FLEX
                                                                  : drts_pkg::DRIVE_EXT;
                            demand_moving = 1'b1;
                            demand_time   = '0;
                        end
                    end
                    drts_pkg::CH_O:
                    begin
                        demand_moving = 1'b0;
                        bridge_word   = drts_pkg::DRIVE_STOP;
                    end
                    drts_pkg::CH_Z:
                    begin
                        demand_mode   = 1'b0;
                        demand_moving = 1'b0;
                        sys_paused    = 1'b0;
                        enter_phase(drts_pkg::PH_FLEX);
                    end
                    default: ;
                endcase
            end
            if (c == drts_pkg::CH_P)
            begin
                sys_paused = !sys_paused;
                if (sys_paused)
                begin
                    demand_moving = 1'b0;
                    bridge_word   = drts_pkg::DRIVE_STOP;
                end
                else
                begin
                    // Resuming restarts the phase timer and, outside on-demand mode,
                    // drives the bridges for the stored phase even before calibration.
                    phase_time = '0;
                    if (!demand_mode)
                        enter_phase(cur_phase);
                end
            end
            if (c == drts_pkg::CH_R)
            begin
                is_cal        = 1'b0;
                sys_paused    = 1'b0;
                demand_mode   = 1'b0;
                demand_moving = 1'b0;
                bridge_word   = drts_pkg::DRIVE_STOP;
            end
        end
        r = pin_outs(bridge_word[1:0], bridge_word[3:2], cur_phase, is_cal, sys_paused,
                     demand_mode, demand_moving);
    endtask

    task automatic add_step(input logic k, input logic [7:0] c, input bit pin,
                            input drts_pkg::result_t w);
        step_t s;
        s.what   = STEP_ITEM;
        s.kind   = k;
        s.cmd    = c;
        s.pinned = pin;
        s.want   = w;
        s.move_v  = '0;
        s.pause_v = '0;
        s.jog_v   = '0;
        steps.push_back(s);
    endtask

    task automatic send_item(input logic k, input logic [7:0] b, input bit pin,
                             input drts_pkg::result_t w);
        pin_t p;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        p.pinned = pin;
        p.want   = w;
        pinned_q.push_back(p);
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= k;
        item_ch.command_byte <= b;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Holds requests off until every outstanding result has come back.
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input drts_pkg::cfg_index_t idx, input drts_pkg::cfg_word_t v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_config(input drts_pkg::cfg_word_t mv, input drts_pkg::cfg_word_t ps,
                               input drts_pkg::cfg_word_t jg);
        put_reg(drts_pkg::REG_MOVE_TICKS, mv);
        put_reg(drts_pkg::REG_PAUSE_TICKS, ps);
        put_reg(drts_pkg::REG_JOG_TICKS, jg);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
        result_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);

    // Result check, request prediction and register shadowing, in that order at each edge.
    always @(posedge clk)
    begin
        drts_pkg::result_t got;
        drts_pkg::result_t want;
        pin_t              pin;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = pin_outs(result_ch.ext_drive, result_ch.flex_drive,
                               drts_pkg::phase_t'(result_ch.phase), result_ch.calibrated,
                               result_ch.paused, result_ch.on_demand_mode,
                               result_ch.on_demand_moving);
                if (expected_outputs.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with no request pending: expected none, got %h",
                             $time, got);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display({"%0t: result mismatch: expected ext=%0d flex=%0d phase=%0d ",
                                  "cal=%0b paused=%0b mode=%0b moving=%0b, got ext=%0d ",
                                  "flex=%0d phase=%0d cal=%0b paused=%0b mode=%0b moving=%0b"},
                                 $time, want.ext_drive, want.flex_drive, want.phase,
                                 want.calibrated, want.paused, want.on_demand_mode,
                                 want.on_demand_moving, got.ext_drive, got.flex_drive,
                                 got.phase, got.calibrated, got.paused, got.on_demand_mode,
                                 got.on_demand_moving);
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                predict_outputs(item_ch.kind, item_ch.command_byte, want);
                pin = pinned_q.pop_front();
                expected_outputs.push_back(pin.pinned ? pin.want : want);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    drts_pkg::REG_MOVE_TICKS:  move_len  = cfg_ch.data;
                    drts_pkg::REG_PAUSE_TICKS: pause_len = cfg_ch.data;
                    drts_pkg::REG_JOG_TICKS:   jog_len   = cfg_ch.data;
                    default: ;
                endcase
            end
        end
    end

    initial
    begin
        step_t      s;
        logic       k;
        logic [7:0] b;
        int         pick;

        rst_n                = 1'b0;
        quiet                = 1'b0;
        mismatch_count       = 0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_TICK;
        item_ch.command_byte = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = drts_pkg::REG_MOVE_TICKS;
        cfg_ch.data          = '0;

        // Directed table, run with the reset durations first.
        add_step(KIND_TICK, 8'hFF, 1'b1,
                 pin_outs(2'd0, 2'd0, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_W - drts_pkg::CASE_OFFSET, 1'b1,
                 pin_outs(2'd1, 2'd0, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_TICK, 8'h00, 1'b0, '0);
        // An unknown letter only cancels the running jog.
        add_step(KIND_CMD, 8'h78, 1'b1,
                 pin_outs(2'd0, 2'd0, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_A, 1'b1,
                 pin_outs(2'd0, 2'd2, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_LF, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_CR, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_SPACE, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_S - drts_pkg::CASE_OFFSET, 1'b1,
                 pin_outs(2'd2, 2'd0, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_D, 1'b1,
                 pin_outs(2'd0, 2'd1, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_P, 1'b1,
                 pin_outs(2'd0, 2'd0, drts_pkg::PH_FLEX, 1'b0, 1'b1, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_P, 1'b1,
                 pin_outs(2'd1, 2'd1, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_M, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_Z, 1'b1,
                 pin_outs(2'd1, 2'd1, drts_pkg::PH_FLEX, 1'b1, 1'b0, 1'b0, 1'b0));
        add_step(KIND_TICK, drts_pkg::CH_Z, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_O, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_L, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_M - drts_pkg::CASE_OFFSET, 1'b1,
                 pin_outs(2'd0, 2'd0, drts_pkg::PH_FLEX, 1'b1, 1'b0, 1'b1, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_L, 1'b1,
                 pin_outs(2'd1, 2'd1, drts_pkg::PH_FLEX, 1'b1, 1'b0, 1'b1, 1'b1));
        add_step(KIND_CMD, drts_pkg::CH_E - drts_pkg::CASE_OFFSET, 1'b1,
                 pin_outs(2'd2, 2'd2, drts_pkg::PH_FLEX, 1'b1, 1'b0, 1'b1, 1'b1));
        add_step(KIND_CMD, drts_pkg::CH_P, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_E, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_P, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_W, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_R, 1'b1,
                 pin_outs(2'd0, 2'd0, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        // Zero durations: jogs never start and every phase ends on the next tick.
        s.what    = STEP_CFG;
        s.move_v  = '0;
        s.pause_v = '0;
        s.jog_v   = '0;
        steps.push_back(s);
        add_step(KIND_CMD, drts_pkg::CH_W, 1'b1,
                 pin_outs(2'd0, 2'd0, drts_pkg::PH_FLEX, 1'b0, 1'b0, 1'b0, 1'b0));
        add_step(KIND_CMD, drts_pkg::CH_Z, 1'b1,
                 pin_outs(2'd1, 2'd1, drts_pkg::PH_FLEX, 1'b1, 1'b0, 1'b0, 1'b0));
        add_step(KIND_TICK, 8'h00, 1'b1,
                 pin_outs(2'd0, 2'd0, drts_pkg::PH_FLEX_PAUSE, 1'b1, 1'b0, 1'b0, 1'b0));
        add_step(KIND_TICK, 8'h00, 1'b1,
                 pin_outs(2'd2, 2'd2, drts_pkg::PH_EXT, 1'b1, 1'b0, 1'b0, 1'b0));
        add_step(KIND_TICK, 8'h00, 1'b0, '0);
        add_step(KIND_TICK, 8'h00, 1'b0, '0);
        add_step(KIND_CMD, drts_pkg::CH_R - drts_pkg::CASE_OFFSET, 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].what == STEP_CFG)
            begin
                settle();
                load_config(steps[i].move_v, steps[i].pause_v, steps[i].jog_v);
            end
            else
                send_item(steps[i].kind, steps[i].cmd, steps[i].pinned, steps[i].want);
        end

        for (int r = 0; r < ROUNDS; r++)
        begin
            settle();
            case (r)
                0: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: load_config(16'd1, 16'd1, 16'd1);
                default: load_config(drts_pkg::cfg_word_t'($urandom_range(0, 24)),
                                     drts_pkg::cfg_word_t'($urandom_range(0, 12)),
                                     drts_pkg::cfg_word_t'($urandom_range(0, 10)));
            endcase
            quiet = (r == 3);
            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                if (r == 1 && n == ROUND_ITEMS / 2)
                    settle();
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    k = KIND_TICK;
                    b = 8'($urandom_range(0, 255));
                end
                else if (pick < 90)
                begin
                    k = KIND_CMD;
                    case ($urandom_range(0, 15))
                        0:       b = drts_pkg::CH_W;
                        1:       b = drts_pkg::CH_S;
                        2:       b = drts_pkg::CH_D;
                        3:       b = drts_pkg::CH_A;
                        4, 5:    b = drts_pkg::CH_Z;
                        6, 7:    b = drts_pkg::CH_M;
                        8, 9:    b = drts_pkg::CH_L;
                        10, 11:  b = drts_pkg::CH_E;
                        12:      b = drts_pkg::CH_O;
                        13:      b = drts_pkg::CH_P;
                        14:      b = drts_pkg::CH_R;
                        default: b = drts_pkg::CH_SPACE;
                    endcase
                    if (b != drts_pkg::CH_SPACE && $urandom_range(0, 3) == 0)
                        b = b - drts_pkg::CASE_OFFSET;
                end
                else
                begin
                    k = KIND_CMD;
                    b = 8'($urandom_range(0, 255));
                end
                send_item(k, b, 1'b0, '0);
            end
        end

        quiet = 1'b0;
        settle();
        if (mismatch_count == 0 && expected_outputs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/drts_pkg.sv
rtl/drts_if.sv
rtl/dual_reel_therapy_sequencer.sv
tb/tb_dual_reel_therapy_sequencer.sv
